// ----- design/qes_pkg.sv -----
// qes_pkg: shared types, constants and binary32 helper functions
// for the quadratic equation solver; no dependencies
`default_nettype none
package qes_pkg;

  localparam logic [31:0] QNAN      = 32'h7fc0_0000;
  // smallest binary32 magnitude that is not below 1e-14
  localparam logic [30:0] SMALL_MAG = 31'h2834_24dd;
  localparam logic [31:0] FP_TWO    = 32'h4000_0000;
  localparam logic [31:0] FP_FOUR   = 32'h4080_0000;

  localparam int unsigned MUL_LAT      = 3;
  localparam int unsigned ADD_LAT      = 4;
  localparam int unsigned SQRT_BITS    = 25;
  localparam int unsigned DIV_BITS     = 26;
  localparam int unsigned SQRT_BPS_DEF = 5;
  localparam int unsigned DIV_BPS_DEF  = 4;

  typedef logic signed [10:0] exp_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_ONE  = 2'd1,
    ST_TWO  = 2'd2,
    ST_ALL  = 2'd3
  } status_e;

  // unpacked operand: man has its leading one at bit 23, value man/2^23 * 2^(exp-127)
  typedef struct packed {
    logic       nan;
    logic       inf;
    logic       zero;
    logic       sgn;
    exp_t       exp;
    logic [23:0] man;
  } fp_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic fp_t fp_unpack(input logic [31:0] u);
    fp_t r;
    logic [4:0] lz;
    lz     = lzc24({1'b0, u[22:0]});
    r.sgn  = u[31];
    r.nan  = (u[30:23] == 8'hff) && (u[22:0] != 23'd0);
    r.inf  = (u[30:23] == 8'hff) && (u[22:0] == 23'd0);
    r.zero = (u[30:0] == 31'd0);
    if (u[30:23] != 8'd0) begin
      r.exp = exp_t'({3'b000, u[30:23]});
      r.man = {1'b1, u[22:0]};
    end else begin
      r.exp = exp_t'(11'sd1 - exp_t'({6'd0, lz}));
      r.man = {1'b0, u[22:0]} << lz;
    end
    return r;
  endfunction

  // m[26] is the leading one, m[2:0] guard, round and sticky
  function automatic logic [31:0] fp_round_pack(input logic sgn, input exp_t e,
                                                input logic [26:0] m);
    logic [26:0] ms;
    logic [7:0]  ef;
    logic [4:0]  sh;
    logic        inc;
    logic [30:0] mag;
    logic [31:0] res;
    ms = m;
    ef = e[7:0];
    sh = 5'd0;
    if (e <= 0) begin
      ef = 8'd0;
      if (e < -25) begin
        ms = {26'd0, |m};
      end else begin
        sh    = 5'(11'sd1 - e);
        ms    = m >> sh;
        ms[0] = ms[0] | ((ms << sh) != m);
      end
    end
    inc = ms[2] & (ms[3] | ms[1] | ms[0]);
    mag = {ef, ms[25:3]} + {30'd0, inc};
    if (e >= 255) res = {sgn, 8'hff, 23'd0};
    else          res = {sgn, mag};
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/qes_if.sv -----
// qes_coef_if and qes_root_if: valid/ready channels of the solver
// no dependencies
`default_nettype none
interface qes_coef_if;
  logic        valid;
  logic        ready;
  logic [31:0] coef_square;
  logic [31:0] coef_linear;
  logic [31:0] coef_constant;
  modport source (output valid, coef_square, coef_linear, coef_constant, input ready);
  modport sink   (input valid, coef_square, coef_linear, coef_constant, output ready);
endinterface

interface qes_root_if;
  logic        valid;
  logic        ready;
  logic [1:0]  root_status;
  logic [31:0] root_first;
  logic [31:0] root_second;
  modport source (output valid, root_status, root_first, root_second, input ready);
  modport sink   (input valid, root_status, root_first, root_second, output ready);
endinterface
`default_nettype wire

// ----- design/qes_delay.sv -----
// qes_delay: enabled shift line that keeps side data aligned with the units
// no dependencies
`default_nettype none
module qes_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  wire              clk_i,
  input  wire              en_i,
  input  wire [WIDTH-1:0]  d_i,
  output logic [WIDTH-1:0] q_o
);
  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];
endmodule
`default_nettype wire

// ----- design/qes_fmul.sv -----
// qes_fmul: three-stage binary32 multiplier, round to nearest even
// depends on qes_pkg
`default_nettype none
module qes_fmul (
  input  wire         clk_i,
  input  wire         en_i,
  input  wire [31:0]  a_i,
  input  wire [31:0]  b_i,
  output logic [31:0] y_o
);
  import qes_pkg::*;

  fp_t         xa_q, xb_q;
  logic [47:0] prod_q;
  exp_t        e_q, e_d;
  logic        sgn_q, nan_q, inf_q, zero_q;
  logic [26:0] m_d;
  logic [31:0] y_d, y_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q   <= fp_unpack(a_i);
      xb_q   <= fp_unpack(b_i);
      prod_q <= xa_q.man * xb_q.man;
      e_q    <= xa_q.exp + xb_q.exp - exp_t'(127);
      sgn_q  <= xa_q.sgn ^ xb_q.sgn;
      nan_q  <= xa_q.nan | xb_q.nan | (xa_q.inf & xb_q.zero) | (xa_q.zero & xb_q.inf);
      inf_q  <= xa_q.inf | xb_q.inf;
      zero_q <= xa_q.zero | xb_q.zero;
      y_q    <= y_d;
    end
  end

  always_comb begin
    if (prod_q[47]) begin
      m_d = {prod_q[47:22], |prod_q[21:0]};
      e_d = e_q + exp_t'(1);
    end else begin
      m_d = {prod_q[46:21], |prod_q[20:0]};
      e_d = e_q;
    end
    if (nan_q)       y_d = QNAN;
    else if (inf_q)  y_d = {sgn_q, 8'hff, 23'd0};
    else if (zero_q) y_d = {sgn_q, 31'd0};
    else             y_d = fp_round_pack(sgn_q, e_d, m_d);
  end

  assign y_o = y_q;
endmodule
`default_nettype wire

// ----- design/qes_fadd.sv -----
// qes_fadd: four-stage binary32 adder (swap, align and add, count, normalize and round)
// depends on qes_pkg
`default_nettype none
module qes_fadd (
  input  wire         clk_i,
  input  wire         en_i,
  input  wire [31:0]  a_i,
  input  wire [31:0]  b_i,
  output logic [31:0] y_o
);
  import qes_pkg::*;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sgn;
    logic        neg0;
    exp_t        ex;
    logic [27:0] sum;
  } add_t;

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    n = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) n = 5'(27 - i);
    end
    return n;
  endfunction

  fp_t         big_d, sml_d, big_q, sml_q;
  add_t        al_d, al_q, cn_q;
  logic [4:0]  lz_q;
  logic [31:0] y_d, y_q;

  // larger magnitude goes first
  always_comb begin
    fp_t ua, ub;
    ua = fp_unpack(a_i);
    ub = fp_unpack(b_i);
    if (b_i[30:0] > a_i[30:0]) begin
      big_d = ub;
      sml_d = ua;
    end else begin
      big_d = ua;
      sml_d = ub;
    end
  end

  always_comb begin
    exp_t        diff;
    logic [26:0] mx, my0, my;
    logic        sub;
    diff = big_q.exp - sml_q.exp;
    mx   = {big_q.man, 3'b000};
    my0  = {sml_q.man, 3'b000};
    if (diff > 26) begin
      my = {26'd0, |sml_q.man};
    end else begin
      my    = my0 >> diff[4:0];
      my[0] = my[0] | ((my << diff[4:0]) != my0);
    end
    sub       = big_q.sgn ^ sml_q.sgn;
    al_d.sum  = sub ? ({1'b0, mx} - {1'b0, my}) : ({1'b0, mx} + {1'b0, my});
    al_d.nan  = big_q.nan | sml_q.nan | (big_q.inf & sml_q.inf & sub);
    al_d.inf  = big_q.inf | sml_q.inf;
    al_d.sgn  = big_q.sgn;
    al_d.neg0 = big_q.sgn & sml_q.sgn;
    al_d.ex   = big_q.exp;
  end

  always_comb begin
    logic [27:0] t;
    logic [26:0] m;
    exp_t        e;
    t = cn_q.sum << lz_q;
    m = {t[27:2], |t[1:0]};
    e = cn_q.ex + exp_t'(1) - exp_t'({6'd0, lz_q});
    if (cn_q.nan)                y_d = QNAN;
    else if (cn_q.inf)           y_d = {cn_q.sgn, 8'hff, 23'd0};
    else if (cn_q.sum == 28'd0)  y_d = {cn_q.neg0, 31'd0};
    else                         y_d = fp_round_pack(cn_q.sgn, e, m);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big_q <= big_d;
      sml_q <= sml_d;
      al_q  <= al_d;
      cn_q  <= al_q;
      lz_q  <= lzc28(al_q.sum);
      y_q   <= y_d;
    end
  end

  assign y_o = y_q;
endmodule
`default_nettype wire

// ----- design/qes_fsqrt.sv -----
// qes_fsqrt: pipelined digit-recurrence square root of a positive binary32
// depends on qes_pkg
`default_nettype none
module qes_fsqrt #(
  parameter int unsigned BPS = qes_pkg::SQRT_BPS_DEF
) (
  input  wire         clk_i,
  input  wire         en_i,
  input  wire [31:0]  a_i,
  output logic [31:0] y_o
);
  import qes_pkg::*;

  localparam int unsigned STG = (SQRT_BITS + BPS - 1) / BPS;

  typedef struct packed {
    logic        inf;
    exp_t        eo;
    logic [49:0] rad;
    logic [25:0] rem;
    logic [24:0] q;
  } sq_t;

  sq_t         st_d [STG+1];
  sq_t         st_q [STG+1];
  logic [31:0] y_d, y_q;

  // even exponent, radicand scaled for a 25-bit root
  always_comb begin
    fp_t         u;
    exp_t        ei, ea;
    logic [25:0] mm;
    u  = fp_unpack(a_i);
    ei = u.exp - exp_t'(150);
    if (ei[0]) begin
      mm = {1'b0, u.man, 1'b0};
      ea = ei - exp_t'(1);
    end else begin
      mm = {u.man, 2'b00};
      ea = ei - exp_t'(2);
    end
    st_d[0].inf = u.inf;
    st_d[0].eo  = ((ea - exp_t'(24)) >>> 1) + exp_t'(1);
    st_d[0].rad = {mm, 24'd0};
    st_d[0].rem = 26'd0;
    st_d[0].q   = 25'd0;
  end

  for (genvar k = 0; k < STG; k++) begin : g_stage
    always_comb begin
      sq_t         s;
      logic [27:0] rm, tr;
      s = st_q[k];
      for (int j = 0; j < BPS; j++) begin
        if (k * BPS + j < SQRT_BITS) begin
          rm    = {s.rem, s.rad[49:48]};
          tr    = {1'b0, s.q, 2'b01};
          s.rad = s.rad << 2;
          if (rm >= tr) begin
            s.rem = 26'(rm - tr);
            s.q   = {s.q[23:0], 1'b1};
          end else begin
            s.rem = rm[25:0];
            s.q   = {s.q[23:0], 1'b0};
          end
        end
      end
      st_d[k+1] = s;
    end
  end

  always_comb begin
    sq_t         f;
    logic [23:0] q24;
    logic        inc;
    logic [24:0] qq;
    exp_t        ef;
    f   = st_q[STG];
    q24 = f.q[24:1];
    inc = f.q[0] & ((f.rem != 26'd0) | q24[0]);
    qq  = {1'b0, q24} + {24'd0, inc};
    ef  = f.eo + exp_t'(150) + exp_t'({10'd0, qq[24]});
    if (f.inf) y_d = {1'b0, 8'hff, 23'd0};
    else       y_d = {1'b0, ef[7:0], qq[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= STG; k++) st_q[k] <= st_d[k];
      y_q <= y_d;
    end
  end

  assign y_o = y_q;
endmodule
`default_nettype wire

// ----- design/qes_fdiv.sv -----
// qes_fdiv: pipelined restoring binary32 divider, round to nearest even
// depends on qes_pkg
`default_nettype none
module qes_fdiv #(
  parameter int unsigned BPS = qes_pkg::DIV_BPS_DEF
) (
  input  wire         clk_i,
  input  wire         en_i,
  input  wire [31:0]  a_i,
  input  wire [31:0]  b_i,
  output logic [31:0] y_o
);
  import qes_pkg::*;

  localparam int unsigned STG = (DIV_BITS + BPS - 1) / BPS;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sgn;
    exp_t        ex;
    logic [23:0] dv;
    logic [25:0] rem;
    logic [25:0] q;
  } dv_t;

  dv_t         st_d [STG+1];
  dv_t         st_q [STG+1];
  logic [31:0] y_d, y_q;

  // prescale the dividend so the quotient lies in [1,2)
  always_comb begin
    fp_t  ux, uy;
    logic lt;
    ux = fp_unpack(a_i);
    uy = fp_unpack(b_i);
    lt = ux.man < uy.man;
    st_d[0].nan  = ux.nan | uy.nan | (ux.zero & uy.zero) | (ux.inf & uy.inf);
    st_d[0].inf  = ux.inf | uy.zero;
    st_d[0].zero = ux.zero | uy.inf;
    st_d[0].sgn  = ux.sgn ^ uy.sgn;
    st_d[0].ex   = ux.exp - uy.exp + exp_t'(127) - exp_t'({10'd0, lt});
    st_d[0].dv   = uy.man;
    st_d[0].rem  = lt ? {1'b0, ux.man, 1'b0} : {2'b00, ux.man};
    st_d[0].q    = 26'd0;
  end

  for (genvar k = 0; k < STG; k++) begin : g_stage
    always_comb begin
      dv_t s;
      s = st_q[k];
      for (int j = 0; j < BPS; j++) begin
        if (k * BPS + j < DIV_BITS) begin
          if (s.rem >= {2'b00, s.dv}) begin
            s.rem = (s.rem - {2'b00, s.dv}) << 1;
            s.q   = {s.q[24:0], 1'b1};
          end else begin
            s.rem = s.rem << 1;
            s.q   = {s.q[24:0], 1'b0};
          end
        end
      end
      st_d[k+1] = s;
    end
  end

  always_comb begin
    dv_t f;
    f = st_q[STG];
    if (f.nan)       y_d = QNAN;
    else if (f.inf)  y_d = {f.sgn, 8'hff, 23'd0};
    else if (f.zero) y_d = {f.sgn, 31'd0};
    else             y_d = fp_round_pack(f.sgn, f.ex, {f.q, f.rem != 26'd0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= STG; k++) st_q[k] <= st_d[k];
      y_q <= y_d;
    end
  end

  assign y_o = y_q;
endmodule
`default_nettype wire

// ----- design/quadratic_equation_solver.sv -----
// quadratic_equation_solver: real roots of a*x^2 + b*x + c = 0 on binary32 coefficients
// depends on qes_pkg, qes_if, qes_delay, qes_fmul, qes_fadd, qes_fsqrt, qes_fdiv
//
// usage:
//  - coef_i carries one request of three binary32 coefficients, root_o one result
//    of a status (none, one, two, every x) and two binary32 roots
//  - a request is taken at a rising edge with valid and ready high; one result
//    comes back per request, in order
//  - a request passes in order through 4*a, b*b and 2*a, then (4a)*c, the
//    discriminant add, the square root, -b +/- sqrt, the divide and the
//    output register; the sqrt and divide iterations per stage set how many
//    stages those two units have
//  - one request per cycle, unless stalled; no state is kept between requests
//  - when the receiver stalls with a result waiting, the whole pipeline holds
//    and coef_i.ready drops until root_o.ready rises; nothing is lost
//  - reset clears the valid bits only, payload registers are left as they are
`default_nettype none
module quadratic_equation_solver #(
  parameter int unsigned SQRT_BPS = qes_pkg::SQRT_BPS_DEF,
  parameter int unsigned DIV_BPS  = qes_pkg::DIV_BPS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  qes_coef_if.sink   coef_i,
  qes_root_if.source root_o
);
  import qes_pkg::*;

  localparam int unsigned SQRT_LAT = (SQRT_BITS + SQRT_BPS - 1) / SQRT_BPS + 2;
  localparam int unsigned DIV_LAT  = (DIV_BITS + DIV_BPS - 1) / DIV_BPS + 2;
  // cycle at which each intermediate sits in a register
  localparam int unsigned T_FAC = 2 * MUL_LAT;
  localparam int unsigned T_D   = T_FAC + ADD_LAT;
  localparam int unsigned T_S   = T_D + SQRT_LAT;
  localparam int unsigned T_PN  = T_S + ADD_LAT;
  localparam int unsigned T_R   = T_PN + DIV_LAT;
  localparam int unsigned LAT   = T_R + 1;

  typedef struct packed {
    logic        small_a;
    logic        small_b;
    logic        c_zero;
    logic [31:0] b;
    logic [31:0] c;
  } lin_t;

  typedef struct packed {
    logic pos;
    logic zero;
  } dflag_t;

  logic        en;
  logic [LAT-1:0] vld_q;

  logic [31:0] coef_a, coef_b, coef_c;
  lin_t        lin_in, lin_s, lin_p;
  dflag_t      dflag_d, dflag_p;
  logic [31:0] bb, fa, twoa, c_m, bb_m, fac, disc, sroot;
  logic [31:0] nb_s, nb_p, sum_p, sum_n, twoa_p;
  logic [31:0] num1, den1, quo1, quo2;
  status_e     status_d, status_r;
  logic [1:0]  status_raw;

  logic [1:0]  status_q;
  logic [31:0] first_q, second_q;

  // one global advance: the pipeline moves unless a result is held at the output
  assign en           = !root_o.valid || root_o.ready;
  assign coef_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], coef_i.valid};
    end
  end

  assign root_o.valid = vld_q[LAT-1];

  assign coef_a = coef_i.coef_square;
  assign coef_b = coef_i.coef_linear;
  assign coef_c = coef_i.coef_constant;

  // linear-case tests on the raw coefficients
  always_comb begin
    lin_in.small_a = coef_a[30:0] < SMALL_MAG;
    lin_in.small_b = coef_b[30:0] < SMALL_MAG;
    lin_in.c_zero  = coef_c[30:0] == 31'd0;
    lin_in.b       = coef_b;
    lin_in.c       = coef_c;
  end

  // first products
  qes_fmul u_mul_bb (.clk_i, .en_i(en), .a_i(coef_b), .b_i(coef_b), .y_o(bb));
  qes_fmul u_mul_fa (.clk_i, .en_i(en), .a_i(FP_FOUR), .b_i(coef_a), .y_o(fa));
  qes_fmul u_mul_2a (.clk_i, .en_i(en), .a_i(FP_TWO), .b_i(coef_a), .y_o(twoa));

  qes_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_c (
    .clk_i, .en_i(en), .d_i(coef_c), .q_o(c_m)
  );

  // (4a)*c
  qes_fmul u_mul_fac (.clk_i, .en_i(en), .a_i(fa), .b_i(c_m), .y_o(fac));

  qes_delay #(.WIDTH(32), .DEPTH(T_FAC - MUL_LAT)) u_dly_bb (
    .clk_i, .en_i(en), .d_i(bb), .q_o(bb_m)
  );

  // discriminant b*b - (4a)*c
  qes_fadd u_add_disc (
    .clk_i, .en_i(en), .a_i(bb_m), .b_i({~fac[31], fac[30:0]}), .y_o(disc)
  );

  // sign of the discriminant, a nan counts as neither positive nor zero
  always_comb begin
    dflag_d.zero = disc[30:0] == 31'd0;
    dflag_d.pos  = !disc[31] && !dflag_d.zero &&
                   !((disc[30:23] == 8'hff) && (disc[22:0] != 23'd0));
  end

  qes_fsqrt #(.BPS(SQRT_BPS)) u_sqrt (.clk_i, .en_i(en), .a_i(disc), .y_o(sroot));

  qes_delay #(.WIDTH($bits(lin_t)), .DEPTH(T_S)) u_dly_lin_s (
    .clk_i, .en_i(en), .d_i(lin_in), .q_o(lin_s)
  );

  assign nb_s = {~lin_s.b[31], lin_s.b[30:0]};

  // -b + sqrt and -b - sqrt
  qes_fadd u_add_p (.clk_i, .en_i(en), .a_i(nb_s), .b_i(sroot), .y_o(sum_p));
  qes_fadd u_add_n (
    .clk_i, .en_i(en), .a_i(nb_s), .b_i({~sroot[31], sroot[30:0]}), .y_o(sum_n)
  );

  qes_delay #(.WIDTH($bits(lin_t)), .DEPTH(ADD_LAT)) u_dly_lin_p (
    .clk_i, .en_i(en), .d_i(lin_s), .q_o(lin_p)
  );
  qes_delay #(.WIDTH($bits(dflag_t)), .DEPTH(T_PN - T_D)) u_dly_dflag (
    .clk_i, .en_i(en), .d_i(dflag_d), .q_o(dflag_p)
  );
  qes_delay #(.WIDTH(32), .DEPTH(T_PN - MUL_LAT)) u_dly_twoa (
    .clk_i, .en_i(en), .d_i(twoa), .q_o(twoa_p)
  );

  assign nb_p = {~lin_p.b[31], lin_p.b[30:0]};

  // divider operands and status: linear root -c/b, double root -b/(2a),
  // otherwise the plus-sqrt branch
  always_comb begin
    num1 = sum_p;
    den1 = twoa_p;
    if (lin_p.small_a) begin
      num1 = {~lin_p.c[31], lin_p.c[30:0]};
      den1 = lin_p.b;
      if (!lin_p.small_b)     status_d = ST_ONE;
      else if (lin_p.c_zero)  status_d = ST_ALL;
      else                    status_d = ST_NONE;
    end else if (dflag_p.pos) begin
      status_d = ST_TWO;
    end else if (dflag_p.zero) begin
      num1     = nb_p;
      status_d = ST_ONE;
    end else begin
      status_d = ST_NONE;
    end
  end

  qes_fdiv #(.BPS(DIV_BPS)) u_div_1 (.clk_i, .en_i(en), .a_i(num1), .b_i(den1), .y_o(quo1));
  qes_fdiv #(.BPS(DIV_BPS)) u_div_2 (.clk_i, .en_i(en), .a_i(sum_n), .b_i(twoa_p), .y_o(quo2));

  qes_delay #(.WIDTH(2), .DEPTH(DIV_LAT)) u_dly_status (
    .clk_i, .en_i(en), .d_i(status_d), .q_o(status_raw)
  );

  assign status_r = status_e'(status_raw);

  // output register, unused roots forced to zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= status_r;
      first_q  <= (status_r == ST_ONE || status_r == ST_TWO) ? quo1 : 32'd0;
      second_q <= (status_r == ST_TWO) ? quo2 : 32'd0;
    end
  end

  assign root_o.root_status = status_q;
  assign root_o.root_first  = first_q;
  assign root_o.root_second = second_q;

  // no-root and every-x results carry no roots
  a_empty_roots : assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid && (root_o.root_status == ST_NONE || root_o.root_status == ST_ALL)
    |-> root_o.root_first == 32'd0 && root_o.root_second == 32'd0)
    else $error("root given without a root status");

  // a single root leaves the second field clear
  a_single_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid && root_o.root_status == ST_ONE |-> root_o.root_second == 32'd0)
    else $error("second root given with one-root status");

  // a stall freezes every valid bit in the pipeline
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !coef_i.ready |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ----- dv/quadratic_equation_solver_tb.sv -----
// quadratic_equation_solver_tb: self-checking testbench of the binary32 quadratic solver
// depends on qes_pkg, qes_if and the quadratic_equation_solver rtl
// holds a bit-exact binary32 root predictor, a queued driver and a checking monitor
`default_nettype none
module quadratic_equation_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qes_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 1100;
  localparam int unsigned QUIET_TAIL     = 150;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } coef_req_t;

  typedef struct {
    status_e     status;
    logic [31:0] first;
    logic [31:0] second;
  } root_set_t;

  // binary32 operand split into class flags and an exact value sig * 2^e
  typedef struct {
    bit          nan;
    bit          inf;
    bit          zero;
    bit          sgn;
    logic [23:0] sig;
    int          e;
  } f32_parts_t;

  logic clk;
  logic rst_n;

  qes_coef_if coef_if ();
  qes_root_if root_if ();

  quadratic_equation_solver i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .coef_i (coef_if),
    .root_o (root_if)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // binary32 arithmetic, round to nearest even, subnormals kept
  // ---------------------------------------------------------------------------

  function automatic f32_parts_t f32_split(input logic [31:0] u);
    f32_parts_t r;
    r.sgn  = u[31];
    r.nan  = (u[30:23] == 8'hff) && (u[22:0] != 0);
    r.inf  = (u[30:23] == 8'hff) && (u[22:0] == 0);
    r.zero = (u[30:0] == 0);
    if (u[30:23] != 0) begin
      r.sig = {1'b1, u[22:0]};
      r.e   = int'(u[30:23]) - 150;
    end else begin
      r.sig = {1'b0, u[22:0]};
      r.e   = -149;
    end
    return r;
  endfunction

  // round the exact value (-1)^s * sig * 2^e to binary32
  function automatic logic [31:0] f32_round(input bit s, input logic [127:0] sig, input int e);
    int          msb;
    int          ex;
    int          lsb_e;
    int          k;
    logic [127:0] keep;
    logic [127:0] rem;
    logic [127:0] half;
    if (sig == 0) return {s, 31'd0};
    msb = 0;
    for (int i = 0; i < 128; i++) begin
      if (sig[i]) msb = i;
    end
    ex = msb + e;
    if (ex > 127) return {s, 8'hff, 23'd0};
    lsb_e = (ex - 23 > -149) ? ex - 23 : -149;
    k = lsb_e - e;
    if (k >= 120) return {s, 31'd0};
    if (k > 0) begin
      keep = sig >> k;
      rem  = sig - (keep << k);
      half = 128'd1 << (k - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 1;
    end else begin
      keep = sig << (-k);
    end
    // rounding carried into the next binade
    if (keep == (128'd1 << 24)) begin
      keep  = keep >> 1;
      lsb_e = lsb_e + 1;
    end
    if (lsb_e + 150 >= 255) return {s, 8'hff, 23'd0};
    if (keep >= (128'd1 << 23)) return {s, 8'(lsb_e + 150), keep[22:0]};
    return {s, 8'd0, keep[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] x, input logic [31:0] y);
    f32_parts_t p;
    f32_parts_t q;
    bit         s;
    p = f32_split(x);
    q = f32_split(y);
    s = p.sgn ^ q.sgn;
    if (p.nan || q.nan) return QNAN;
    if ((p.inf && q.zero) || (q.inf && p.zero)) return QNAN;
    if (p.inf || q.inf) return {s, 8'hff, 23'd0};
    if (p.zero || q.zero) return {s, 31'd0};
    return f32_round(s, 128'(p.sig) * 128'(q.sig), p.e + q.e);
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] x, input logic [31:0] y);
    f32_parts_t   p;
    f32_parts_t   q;
    f32_parts_t   t;
    int           d;
    logic [127:0] big;
    logic [127:0] lit;
    p = f32_split(x);
    q = f32_split(y);
    if (p.nan || q.nan) return QNAN;
    if (p.inf && q.inf) return (p.sgn == q.sgn) ? x : QNAN;
    if (p.inf) return x;
    if (q.inf) return y;
    if (p.zero && q.zero) return {p.sgn & q.sgn, 31'd0};
    if (p.zero) return y;
    if (q.zero) return x;
    if (q.e > p.e) begin
      t = p;
      p = q;
      q = t;
    end
    d = p.e - q.e;
    lit = 128'(q.sig);
    // a far smaller addend only matters as a sticky bit
    if (d > 80) begin
      d   = 80;
      lit = 128'd1;
    end
    big = 128'(p.sig) << d;
    if (p.sgn == q.sgn) return f32_round(p.sgn, big + lit, p.e - d);
    if (big == lit) return 32'd0;
    if (big > lit) return f32_round(p.sgn, big - lit, p.e - d);
    return f32_round(q.sgn, lit - big, p.e - d);
  endfunction

  function automatic logic [31:0] f32_div(input logic [31:0] x, input logic [31:0] y);
    f32_parts_t   p;
    f32_parts_t   q;
    bit           s;
    logic [127:0] quo;
    logic [127:0] num;
    p = f32_split(x);
    q = f32_split(y);
    s = p.sgn ^ q.sgn;
    if (p.nan || q.nan) return QNAN;
    if ((p.inf && q.inf) || (p.zero && q.zero)) return QNAN;
    if (p.inf || q.zero) return {s, 8'hff, 23'd0};
    if (q.inf || p.zero) return {s, 31'd0};
    num = 128'(p.sig) << 60;
    quo = num / 128'(q.sig);
    return f32_round(s, (quo << 1) | 128'(quo * 128'(q.sig) != num), p.e - q.e - 61);
  endfunction

  // square root of a positive, non-nan, nonzero value
  function automatic logic [31:0] f32_sqrt(input logic [31:0] x);
    f32_parts_t   p;
    logic [127:0] n;
    logic [127:0] r;
    int           e;
    p = f32_split(x);
    if (p.inf) return x;
    n = 128'(p.sig);
    e = p.e;
    if (e % 2 != 0) begin
      n = n << 1;
      e = e - 1;
    end
    n = n << 60;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      if (((r | (128'd1 << i)) * (r | (128'd1 << i))) <= n) r = r | (128'd1 << i);
    end
    return f32_round(1'b0, (r << 1) | 128'(r * r != n), (e - 60) / 2 - 1);
  endfunction

  function automatic bit below_small(input logic [31:0] u);
    return u[30:0] < SMALL_MAG;
  endfunction

  // expected status and roots for one coefficient set
  function automatic root_set_t solve_roots(input coef_req_t q);
    root_set_t   r;
    logic [31:0] bb;
    logic [31:0] fac;
    logic [31:0] disc;
    logic [31:0] two_a;
    logic [31:0] neg_b;
    logic [31:0] sq;
    r.status = ST_NONE;
    r.first  = 32'd0;
    r.second = 32'd0;
    if (below_small(q.a)) begin
      if (below_small(q.b)) begin
        r.status = (q.c[30:0] == 0) ? ST_ALL : ST_NONE;
      end else begin
        r.status = ST_ONE;
        r.first  = f32_div({~q.c[31], q.c[30:0]}, q.b);
      end
    end else begin
      bb    = f32_mul(q.b, q.b);
      fac   = f32_mul(f32_mul(FP_FOUR, q.a), q.c);
      disc  = f32_add(bb, {~fac[31], fac[30:0]});
      two_a = f32_mul(FP_TWO, q.a);
      neg_b = {~q.b[31], q.b[30:0]};
      if (disc[30:0] == 0) begin
        r.status = ST_ONE;
        r.first  = f32_div(neg_b, two_a);
      end else if (!disc[31] && !(disc[30:23] == 8'hff && disc[22:0] != 0)) begin
        sq       = f32_sqrt(disc);
        r.status = ST_TWO;
        r.first  = f32_div(f32_add(neg_b, sq), two_a);
        r.second = f32_div(f32_add(neg_b, {1'b1, sq[30:0]}), two_a);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  coef_req_t coef_pending[$];
  root_set_t roots_expected[$];
  int unsigned status_seen[4];
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned mismatches;

  function automatic logic [31:0] int_to_f32(input int n);
    return f32_round(n < 0, 128'((n < 0) ? -n : n), 0);
  endfunction

  // a float of moderate size so the quadratic path stays numeric
  function automatic logic [31:0] moderate_f32();
    return {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
  endfunction

  function automatic coef_req_t random_coefs();
    coef_req_t q;
    int        m;
    int        k;
    case ($urandom_range(0, 9))
      0, 1: begin
        // raw patterns: every bit, nan, inf and subnormal alike
        q.a = $urandom;
        q.b = $urandom;
        q.c = $urandom;
      end
      2: begin
        // exact double root: a = m, b = 2mk, c = mk^2
        m   = $urandom_range(1, 15) * (($urandom_range(0, 1) != 0) ? 1 : -1);
        k   = int'($urandom_range(0, 30)) - 15;
        q.a = int_to_f32(m);
        q.b = int_to_f32(2 * m * k);
        q.c = int_to_f32(m * k * k);
      end
      3: begin
        // mostly linear, a at or just below the small threshold
        q.a = {1'($urandom), 31'(SMALL_MAG - 31'($urandom_range(0, 3)))};
        q.b = ($urandom_range(0, 2) == 0) ? {1'($urandom), 31'($urandom_range(0, 1000))}
                                          : moderate_f32();
        q.c = ($urandom_range(0, 2) == 0) ? {1'($urandom), 31'd0} : moderate_f32();
      end
      4: begin
        // small integers give exact discriminants of every sign
        q.a = int_to_f32(int'($urandom_range(0, 20)) - 10);
        q.b = int_to_f32(int'($urandom_range(0, 40)) - 20);
        q.c = int_to_f32(int'($urandom_range(0, 40)) - 20);
      end
      default: begin
        q.a = moderate_f32();
        q.b = moderate_f32();
        q.c = moderate_f32();
      end
    endcase
    return q;
  endfunction

  task automatic queue_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    coef_req_t q;
    q.a = a;
    q.b = b;
    q.c = c;
    coef_pending = {coef_pending, q};
  endtask

  // ---------------------------------------------------------------------------
  // driver and receiver: inputs change at the falling edge
  // ---------------------------------------------------------------------------

  int unsigned send_gap;
  int unsigned recv_stall;
  bit          req_taken;

  always @(posedge clk) begin
    req_taken <= rst_n && coef_if.valid && coef_if.ready;
    if (rst_n && coef_if.valid && coef_if.ready) begin
      roots_expected = {roots_expected, solve_roots(coef_pending[0])};
      requests_sent <= requests_sent + 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (req_taken) void'(coef_pending.pop_front());
      if (coef_if.valid && !req_taken) begin
        // request still waiting for ready: hold it
      end else if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        coef_if.valid <= 1'b0;
      end else if (coef_pending.size() > 0) begin
        if (coef_pending.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          send_gap      <= $urandom_range(0, 5);
          coef_if.valid <= 1'b0;
        end else begin
          coef_if.valid         <= 1'b1;
          coef_if.coef_square   <= coef_pending[0].a;
          coef_if.coef_linear   <= coef_pending[0].b;
          coef_if.coef_constant <= coef_pending[0].c;
        end
      end else begin
        coef_if.valid <= 1'b0;
      end

      // receiver back-pressure in bursts, none in the quiet tail
      if (recv_stall > 0) begin
        recv_stall    <= recv_stall - 1;
        root_if.ready <= 1'b0;
      end else if (coef_pending.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
        recv_stall    <= $urandom_range(0, 5);
        root_if.ready <= 1'b0;
      end else begin
        root_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: results sampled at the rising edge, compared in order
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    root_set_t want;
    if (rst_n && root_if.valid && root_if.ready) begin
      results_checked <= results_checked + 1;
      if (roots_expected.size() == 0) begin
        $error("result with no request outstanding: status %0d first %h second %h",
               root_if.root_status, root_if.root_first, root_if.root_second);
        mismatches = mismatches + 1;
      end else begin
        want = roots_expected.pop_front();
        status_seen[want.status] <= status_seen[want.status] + 1;
        if (root_if.root_status !== want.status) begin
          $error("root_status: expected %0d, actual %0d", want.status, root_if.root_status);
          mismatches = mismatches + 1;
        end
        if (root_if.root_first !== want.first) begin
          $error("root_first: expected %h, actual %h", want.first, root_if.root_first);
          mismatches = mismatches + 1;
        end
        if (root_if.root_second !== want.second) begin
          $error("root_second: expected %h, actual %h", want.second, root_if.root_second);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // watchdog: too long with no request or result moving
  int unsigned idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (coef_if.valid && coef_if.ready) || (root_if.valid && root_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", roots_expected.size());
        $display("FAIL quadratic_equation_solver");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    coef_if.valid         = 1'b0;
    coef_if.coef_square   = 32'd0;
    coef_if.coef_linear   = 32'd0;
    coef_if.coef_constant = 32'd0;
    root_if.ready         = 1'b0;
    send_gap              = 0;
    recv_stall            = 0;
    req_taken             = 1'b0;
    requests_sent         = 0;
    results_checked       = 0;
    mismatches            = 0;
    idle_cycles           = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed: every status, threshold edges, signed zeros, nan, inf, extremes
    queue_coefs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // every x
    queue_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);  // every x, minus zeros
    queue_coefs(32'h0000_0000, 32'h0000_0000, 32'h3f80_0000);  // no root, linear
    queue_coefs(32'h0000_0000, 32'h0000_0000, 32'h7fc0_0001);  // nan c is not zero
    queue_coefs(32'h0000_0001, 32'h4000_0000, 32'h4080_0000);  // linear root -2
    queue_coefs({1'b0, SMALL_MAG - 31'd1}, {1'b1, SMALL_MAG}, 32'h3f80_0000);
    queue_coefs({1'b1, SMALL_MAG}, 32'h0000_0000, 32'h0000_0000);  // a just not small
    queue_coefs(32'h3f80_0000, 32'hc040_0000, 32'h4000_0000);  // two roots 2 and 1
    queue_coefs(32'h3f80_0000, 32'h4000_0000, 32'h3f80_0000);  // double root -1
    queue_coefs(32'h3f80_0000, 32'h0000_0000, 32'h3f80_0000);  // no real root
    queue_coefs(32'h7fc0_0000, 32'h3f80_0000, 32'h3f80_0000);  // nan a
    queue_coefs(32'h3f80_0000, 32'hffa0_0000, 32'h3f80_0000);  // nan b
    queue_coefs(32'h0000_0000, 32'h7f80_0001, 32'h3f80_0000);  // nan b, linear path
    queue_coefs(32'h7f80_0000, 32'h3f80_0000, 32'hbf80_0000);  // infinite a
    queue_coefs(32'h3f80_0000, 32'hff80_0000, 32'h3f80_0000);  // infinite b
    queue_coefs(32'h3f80_0000, 32'h3f80_0000, 32'hff80_0000);  // infinite c
    queue_coefs(32'h7f7f_ffff, 32'h7f7f_ffff, 32'hff7f_ffff);  // overflow everywhere
    queue_coefs(32'h0080_0000, 32'h007f_ffff, 32'h8000_0001);  // subnormals
    queue_coefs(32'h3f80_0000, 32'h2000_0000, 32'h8000_0001);  // tiny discriminant parts
    queue_coefs(32'h0000_0000, 32'h7f7f_ffff, 32'h0000_0001);  // root underflows
    queue_coefs(32'h0000_0000, 32'h0000_0001, 32'h7f7f_ffff);  // b small, no root
    queue_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < RANDOM_ITEMS; i++) coef_pending = {coef_pending, random_coefs()};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (coef_pending.size() != 0 || coef_if.valid || roots_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (64) @(posedge clk);
    if (roots_expected.size() != 0) begin
      $error("%0d results never arrived", roots_expected.size());
      mismatches = mismatches + 1;
    end

    $display("%0d requests sent, %0d results checked", requests_sent, results_checked);
    $display("results by status: none %0d, one %0d, two %0d, every x %0d",
             status_seen[ST_NONE], status_seen[ST_ONE], status_seen[ST_TWO],
             status_seen[ST_ALL]);
    if (mismatches == 0) begin
      $display("PASS quadratic_equation_solver");
    end else begin
      $display("FAIL quadratic_equation_solver");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
design/qes_pkg.sv
design/qes_if.sv
design/qes_delay.sv
design/qes_fmul.sv
design/qes_fadd.sv
design/qes_fsqrt.sv
design/qes_fdiv.sv
design/quadratic_equation_solver.sv
dv/quadratic_equation_solver_tb.sv
